// File: hdl/jat_pkg.sv
// ----------------------------------------------------------------------------
// jat_pkg
// Types, character constants and classifiers for the JSON array tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package jat_pkg;

    // Input item: one text byte plus start flag
    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_of_text;
    } text_item_t;

    // Result item: one per input byte
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] token_byte;
        logic       token_end;
        logic       array_done;
        logic [1:0] error_code;
    } tok_item_t;

    // Parser mode, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_LEAD  = 5'b00010,
        MODE_BARE  = 5'b00100,
        MODE_QUOTE = 5'b01000,
        MODE_TRAIL = 5'b10000
    } mode_t;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_END     = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;
    localparam logic [1:0] ERR_NOOPEN  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    function automatic logic is_bare_start(input logic [7:0] c);
        logic alnum;
        alnum = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
        return alnum || (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_bare_more(input logic [7:0] c);
        return is_bare_start(c) || (c == CH_DOT);
    endfunction

endpackage

`default_nettype wire

// File: hdl/jat_step.sv
// ----------------------------------------------------------------------------
// jat_step
// Next-mode and result logic for one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jat_step (
    input  wire  jat_pkg::mode_t      mode,
    input  wire  jat_pkg::text_item_t item,
    output jat_pkg::mode_t            mode_next,
    output jat_pkg::tok_item_t        result
);

    logic [7:0] c;
    assign c = item.text_byte;

    always_comb
    begin
        mode_next = mode;
        result    = '0;
        if (item.start_of_text)
        begin
            if (c == jat_pkg::CH_OPEN)
            begin
                mode_next = jat_pkg::MODE_LEAD;
            end
            else
            begin
                result.error_code = jat_pkg::ERR_NOOPEN;
                mode_next         = jat_pkg::MODE_IDLE;
            end
        end
        else
        begin
            case (mode)
                jat_pkg::MODE_LEAD:
                begin
                    if (c == jat_pkg::CH_SPACE)
                    begin
                        mode_next = jat_pkg::MODE_LEAD;
                    end
                    else if (c == jat_pkg::CH_NUL)
                    begin
                        result.error_code = jat_pkg::ERR_END;
                        mode_next         = jat_pkg::MODE_IDLE;
                    end
                    else if (jat_pkg::is_bare_start(c))
                    begin
                        result.byte_valid = 1'b1;
                        result.token_byte = c;
                        mode_next         = jat_pkg::MODE_BARE;
                    end
                    else if (c == jat_pkg::CH_QUOTE)
                    begin
                        mode_next = jat_pkg::MODE_QUOTE;
                    end
                    else if (c == jat_pkg::CH_CLOSE)
                    begin
                        result.array_done = 1'b1;
                        mode_next         = jat_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        result.error_code = jat_pkg::ERR_UNKNOWN;
                        mode_next         = jat_pkg::MODE_IDLE;
                    end
                end
                jat_pkg::MODE_QUOTE:
                begin
                    if (c == jat_pkg::CH_NUL)
                    begin
                        result.error_code = jat_pkg::ERR_END;
                        mode_next         = jat_pkg::MODE_IDLE;
                    end
                    else if (c == jat_pkg::CH_QUOTE)
                    begin
                        result.token_end = 1'b1;
                        mode_next        = jat_pkg::MODE_TRAIL;
                    end
                    else
                    begin
                        result.byte_valid = 1'b1;
                        result.token_byte = c;
                    end
                end
                jat_pkg::MODE_BARE,
                jat_pkg::MODE_TRAIL:
                begin
                    if ((mode == jat_pkg::MODE_BARE) && jat_pkg::is_bare_more(c))
                    begin
                        result.byte_valid = 1'b1;
                        result.token_byte = c;
                    end
                    else if ((mode == jat_pkg::MODE_BARE) && (c == jat_pkg::CH_NUL))
                    begin
                        result.error_code = jat_pkg::ERR_END;
                        mode_next         = jat_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        // in bare mode the token ends here; in either mode the byte is then handled as after a token
                        result.token_end = (mode == jat_pkg::MODE_BARE);
                        if (c == jat_pkg::CH_SPACE)
                        begin
                            mode_next = jat_pkg::MODE_TRAIL;
                        end
                        else if (c == jat_pkg::CH_COMMA)
                        begin
                            mode_next = jat_pkg::MODE_LEAD;
                        end
                        else if (c == jat_pkg::CH_CLOSE)
                        begin
                            result.array_done = 1'b1;
                            mode_next         = jat_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            result.error_code = jat_pkg::ERR_UNKNOWN;
                            mode_next         = jat_pkg::MODE_IDLE;
                        end
                    end
                end
                default:
                begin
                    mode_next = jat_pkg::MODE_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/json_array_tokenizer_top.sv
// Path: an accepted item goes first into the input register, then into the
// result register, which drives tok_item; a stall on tok_ready can hold it in either.
// Throughput: one item per cycle while tok_ready keeps the result slot free; the mode
// update is a single short step between the two registers, so items stream back to back.
// Reset (rst_n low, async): both stages empty, mode returns to idle,
// awaiting a start byte.
// ----------------------------------------------------------------------------
// json_array_tokenizer_top
// Byte-stream tokenizer for flat JSON-style arrays: one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module json_array_tokenizer_top (
    input  wire                       clk,
    input  wire                       rst_n,
    // text byte channel
    input  wire                       text_valid,
    output logic                      text_ready,
    input  wire  jat_pkg::text_item_t text_item,
    // token result channel
    output logic                      tok_valid,
    input  wire                       tok_ready,
    output jat_pkg::tok_item_t        tok_item
);

    // Stage 1: registered input item
    logic                slot_vld_reg;
    jat_pkg::text_item_t slot_reg;

    // Parser mode, advanced when stage 1 hands its item to stage 2
    jat_pkg::mode_t      mode_reg;
    jat_pkg::mode_t      mode_next;

    // Stage 2: result register
    logic                res_vld_reg;
    jat_pkg::tok_item_t  res_reg;
    jat_pkg::tok_item_t  res_next;

    logic res_free;
    logic advance;

    // Result slot frees when empty or being taken this cycle
    assign res_free   = !res_vld_reg || tok_ready;
    assign advance    = slot_vld_reg && res_free;
    // Input slot takes a new item when empty or moving on
    assign text_ready = !slot_vld_reg || advance;

    jat_step u_step (
        .mode      (mode_reg),
        .item      (slot_reg),
        .mode_next (mode_next),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            mode_reg     <= jat_pkg::MODE_IDLE;
        end
        else
        begin
            if (text_ready)
            begin
                slot_vld_reg <= text_valid;
            end
            if (res_free)
            begin
                res_vld_reg <= slot_vld_reg;
            end
            if (advance)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (text_ready && text_valid)
        begin
            slot_reg <= text_item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign tok_valid = res_vld_reg;
    assign tok_item  = res_reg;

    // ---------------- assertions ----------------

    // token_byte is zero unless it carries a token character
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_item.byte_valid) |-> (tok_item.token_byte == 8'h00))
        else $error("token_byte nonzero without byte_valid");

    // a token byte never comes with an end, done or error flag
    a_byte_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_item.byte_valid) |->
        (!tok_item.token_end && !tok_item.array_done &&
         (tok_item.error_code == jat_pkg::ERR_NONE)))
        else $error("token byte flagged together with end/done/error");

    // done and error are exclusive
    a_done_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_item.array_done) |->
        (tok_item.error_code == jat_pkg::ERR_NONE))
        else $error("array_done with error");

    // a stalled input item holds, and the mode does not move without it
    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_vld_reg && !advance) |=> ($stable(slot_reg) && $stable(mode_reg)))
        else $error("stage 1 changed while stalled");

    // after done or any error the parser returns to idle
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_next.array_done ||
                     (res_next.error_code != jat_pkg::ERR_NONE)))
        |=> (mode_reg == jat_pkg::MODE_IDLE))
        else $error("mode not idle after done or error");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON array tokenizer. A clocked driver feeds
// text bytes from a queue in random bursts. Each accepted byte is run
// through a local tokenizer model, which queues the result it predicts.
// A clocked monitor with its own stall pattern checks every result against
// that queue, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int TEXT_ITEMS  = 1950;  // bytes to queue in total, at least
    localparam int HOLD_EVERY  = 500;   // sender drains the pipe this often
    localparam int STALL_LIMIT = 4000;  // cycles without any handshake

    // one queued byte; hold makes the sender wait until no result is owed
    typedef struct packed {
        logic                hold;
        jat_pkg::text_item_t item;
    } feed_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                text_valid = 1'b0;
    logic                text_ready;
    jat_pkg::text_item_t text_item  = '0;
    logic                tok_valid;
    logic                tok_ready  = 1'b0;
    jat_pkg::tok_item_t  tok_item;

    feed_t              text_feed[$];         // bytes waiting to be sent
    jat_pkg::tok_item_t predicted_tokens[$];  // results owed by the block, oldest first
    jat_pkg::mode_t     parser_mode = jat_pkg::MODE_IDLE;

    feed_t      next_feed;
    int         burst_left  = 1;
    int         gap_left    = 0;
    int         rx_phase    = 0;
    int         idle_cycles = 0;
    int         random_items = 0;
    int         fail_count  = 0;

    // run statistics
    int         bytes_sent  = 0;
    int         token_ends  = 0;
    int         arrays_done = 0;
    int         err_seen[4] = '{0, 0, 0, 0};

    json_array_tokenizer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_item  (text_item),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_item   (tok_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------------

    // first character of a bare token: alphanumeric or a sign
    function automatic logic starts_bare(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == jat_pkg::CH_PLUS ||
               c == jat_pkg::CH_MINUS;
    endfunction

    function automatic logic continues_bare(input logic [7:0] c);
        return starts_bare(c) || c == jat_pkg::CH_DOT;
    endfunction

    // byte after a finished token: separator, close or error
    function automatic jat_pkg::tok_item_t after_token(input logic [7:0] c,
                                                       input jat_pkg::tok_item_t r);
        jat_pkg::tok_item_t res;
        res = r;
        if (c == jat_pkg::CH_SPACE)
            parser_mode = jat_pkg::MODE_TRAIL;
        else if (c == jat_pkg::CH_COMMA)
            parser_mode = jat_pkg::MODE_LEAD;
        else if (c == jat_pkg::CH_CLOSE)
        begin
            res.array_done = 1'b1;
            parser_mode    = jat_pkg::MODE_IDLE;
        end
        else
        begin
            res.error_code = jat_pkg::ERR_UNKNOWN;
            parser_mode    = jat_pkg::MODE_IDLE;
        end
        return res;
    endfunction

    // advance the parser by one byte and return the result it should give
    function automatic jat_pkg::tok_item_t tokenize_byte(input jat_pkg::text_item_t it);
        jat_pkg::tok_item_t r;
        logic [7:0]         c;
        r = '0;
        c = it.text_byte;
        if (it.start_of_text)
        begin
            // a start flag always restarts, whatever was in progress
            if (c == jat_pkg::CH_OPEN)
                parser_mode = jat_pkg::MODE_LEAD;
            else
            begin
                r.error_code = jat_pkg::ERR_NOOPEN;
                parser_mode  = jat_pkg::MODE_IDLE;
            end
        end
        else
        begin
            case (parser_mode)
                jat_pkg::MODE_LEAD:
                begin
                    if (c == jat_pkg::CH_NUL)
                    begin
                        r.error_code = jat_pkg::ERR_END;
                        parser_mode  = jat_pkg::MODE_IDLE;
                    end
                    else if (starts_bare(c))
                    begin
                        r.byte_valid = 1'b1;
                        r.token_byte = c;
                        parser_mode  = jat_pkg::MODE_BARE;
                    end
                    else if (c == jat_pkg::CH_QUOTE)
                        parser_mode = jat_pkg::MODE_QUOTE;
                    else if (c == jat_pkg::CH_CLOSE)
                    begin
                        // empty array or comma right before the bracket
                        r.array_done = 1'b1;
                        parser_mode  = jat_pkg::MODE_IDLE;
                    end
                    else if (c != jat_pkg::CH_SPACE)
                    begin
                        r.error_code = jat_pkg::ERR_UNKNOWN;
                        parser_mode  = jat_pkg::MODE_IDLE;
                    end
                end
                jat_pkg::MODE_BARE:
                begin
                    if (continues_bare(c))
                    begin
                        r.byte_valid = 1'b1;
                        r.token_byte = c;
                    end
                    else if (c == jat_pkg::CH_NUL)
                    begin
                        r.error_code = jat_pkg::ERR_END;
                        parser_mode  = jat_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        // token ends here; same byte is then handled as after a token
                        r.token_end = 1'b1;
                        r = after_token(c, r);
                    end
                end
                jat_pkg::MODE_QUOTE:
                begin
                    if (c == jat_pkg::CH_NUL)
                    begin
                        r.error_code = jat_pkg::ERR_END;
                        parser_mode  = jat_pkg::MODE_IDLE;
                    end
                    else if (c == jat_pkg::CH_QUOTE)
                    begin
                        r.token_end = 1'b1;
                        parser_mode = jat_pkg::MODE_TRAIL;
                    end
                    else
                    begin
                        r.byte_valid = 1'b1;
                        r.token_byte = c;
                    end
                end
                jat_pkg::MODE_TRAIL:
                    r = after_token(c, r);
                default:
                    parser_mode = jat_pkg::MODE_IDLE;
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic feed(input logic [7:0] b, input logic sof, input logic hold);
        feed_t f;
        f.hold               = hold;
        f.item.text_byte     = b;
        f.item.start_of_text = sof;
        text_feed = {text_feed, f};
        random_items++;
    endtask

    // random character for a bare token; body allows the dot as well
    function automatic logic [7:0] bare_char(input logic body);
        case ($urandom_range(0, body ? 4 : 3))
            0:       return 8'(8'h30 + $urandom_range(0, 9));
            1:       return 8'(8'h41 + $urandom_range(0, 25));
            2:       return 8'(8'h61 + $urandom_range(0, 25));
            3:       return $urandom_range(0, 1) ? jat_pkg::CH_PLUS : jat_pkg::CH_MINUS;
            default: return jat_pkg::CH_DOT;
        endcase
    endfunction

    // well-formed array with random tokens; one in four is cut short and
    // ends in a NUL, a random byte, or simply the next start
    task automatic gen_array(input logic hold);
        logic [7:0] seq[$];
        logic [7:0] b;
        int         n_tok;
        int         cut;
        int         k;
        int         j;
        seq = {seq, jat_pkg::CH_OPEN};
        n_tok = $urandom_range(0, 4);
        repeat ($urandom_range(0, 2)) seq = {seq, jat_pkg::CH_SPACE};
        for (k = 0; k < n_tok; k++)
        begin
            if (k > 0)
                repeat ($urandom_range(0, 2)) seq = {seq, jat_pkg::CH_SPACE};
            if ($urandom_range(0, 2) == 0)
            begin
                seq = {seq, jat_pkg::CH_QUOTE};
                repeat ($urandom_range(0, 6))
                begin
                    b = 8'($urandom_range(1, 255));
                    while (b == jat_pkg::CH_QUOTE)
                        b = 8'($urandom_range(1, 255));
                    seq = {seq, b};
                end
                seq = {seq, jat_pkg::CH_QUOTE};
            end
            else
            begin
                seq = {seq, bare_char(1'b0)};
                repeat ($urandom_range(0, 5)) seq = {seq, bare_char(1'b1)};
            end
            repeat ($urandom_range(0, 2)) seq = {seq, jat_pkg::CH_SPACE};
            if (k < n_tok - 1 || $urandom_range(0, 7) == 0)
                seq = {seq, jat_pkg::CH_COMMA};
        end
        seq = {seq, jat_pkg::CH_CLOSE};

        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, seq.size() - 1);
            while (seq.size() > cut)
                void'(seq.pop_back());
            k = $urandom_range(0, 2);
            if (k == 0)
                seq = {seq, jat_pkg::CH_NUL};
            else if (k == 1)
                seq = {seq, 8'($urandom_range(0, 255))};
        end

        for (j = 0; j < seq.size(); j++)
            feed(seq[j], j == 0, hold && j == 0);

        // occasional junk after the array; the parser drops it when idle
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    // random start byte (usually not a bracket) plus a few stray bytes
    task automatic gen_noise(input logic hold);
        feed(8'($urandom_range(0, 255)), 1'b1, hold);
        repeat ($urandom_range(0, 3)) feed(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int next_hold;

        // directed: stray start, then a byte while idle
        feed("x", 1'b1, 1'b0);
        feed("A", 1'b0, 1'b0);
        // empty array
        feed(jat_pkg::CH_OPEN, 1'b1, 1'b0);
        feed(jat_pkg::CH_CLOSE, 1'b0, 1'b0);
        // leading space, quoted high bytes, trailing space, comma, bare token
        // ended by a comma, then trailing comma before the bracket
        feed(jat_pkg::CH_OPEN, 1'b1, 1'b0);
        feed(jat_pkg::CH_SPACE, 1'b0, 1'b0);
        feed(jat_pkg::CH_QUOTE, 1'b0, 1'b0);
        feed(8'hFF, 1'b0, 1'b0);
        feed(8'h80, 1'b0, 1'b0);
        feed(jat_pkg::CH_QUOTE, 1'b0, 1'b0);
        feed(jat_pkg::CH_SPACE, 1'b0, 1'b0);
        feed(jat_pkg::CH_COMMA, 1'b0, 1'b0);
        feed(jat_pkg::CH_MINUS, 1'b0, 1'b0);
        feed(jat_pkg::CH_DOT, 1'b0, 1'b0);
        feed(jat_pkg::CH_COMMA, 1'b0, 1'b0);
        feed(jat_pkg::CH_CLOSE, 1'b0, 1'b0);
        // bare token closed directly by the bracket
        feed(jat_pkg::CH_OPEN, 1'b1, 1'b0);
        feed("z", 1'b0, 1'b0);
        feed(jat_pkg::CH_CLOSE, 1'b0, 1'b0);
        // empty quoted token, then NUL after it
        feed(jat_pkg::CH_OPEN, 1'b1, 1'b0);
        feed(jat_pkg::CH_QUOTE, 1'b0, 1'b0);
        feed(jat_pkg::CH_QUOTE, 1'b0, 1'b0);
        feed(jat_pkg::CH_NUL, 1'b0, 1'b0);
        // bare token hit by a non-ASCII byte
        feed(jat_pkg::CH_OPEN, 1'b1, 1'b0);
        feed("9", 1'b0, 1'b0);
        feed(8'h80, 1'b0, 1'b0);
        // restart inside a quote, then NUL inside a bare token
        feed(jat_pkg::CH_OPEN, 1'b1, 1'b0);
        feed(jat_pkg::CH_QUOTE, 1'b0, 1'b0);
        feed(jat_pkg::CH_OPEN, 1'b1, 1'b0);
        feed("Q", 1'b0, 1'b0);
        feed(jat_pkg::CH_NUL, 1'b0, 1'b0);
        // NUL where a token should start
        feed(jat_pkg::CH_OPEN, 1'b1, 1'b0);
        feed(jat_pkg::CH_NUL, 1'b0, 1'b0);

        // random part; the first item after the directed part, and one
        // every so often after, waits for the pipe to drain
        next_hold = 0;
        while (random_items < TEXT_ITEMS)
        begin
            if (random_items >= next_hold)
            begin
                next_hold = random_items + HOLD_EVERY;
                if ($urandom_range(0, 9) < 8) gen_array(1'b1);
                else gen_noise(1'b1);
            end
            else if ($urandom_range(0, 9) < 8)
                gen_array(1'b0);
            else
                gen_noise(1'b0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (text_feed.size() != 0 || text_valid)
            @(posedge clk);
        while (predicted_tokens.size() != 0)
            @(posedge clk);
        // two-stage pipe; the extra wait catches any stray result
        repeat (8) @(posedge clk);

        $display("Covered %0d text bytes: %0d tokens ended, %0d arrays closed.",
                 bytes_sent, token_ends, arrays_done);
        $display("Error results: %0d early NUL, %0d bad character, %0d no bracket.",
                 err_seen[jat_pkg::ERR_END], err_seen[jat_pkg::ERR_UNKNOWN],
                 err_seen[jat_pkg::ERR_NOOPEN]);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of random length, random gaps between them. An accepted
    // item is pushed through the model here, so the queue of predicted
    // results follows the exact order of acceptance.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_item  <= '0;
        end
        else
        begin
            if (text_valid && text_ready)
            begin
                predicted_tokens = {predicted_tokens, tokenize_byte(text_item)};
                bytes_sent++;
            end
            // slot is free: either nothing shown or it was just taken
            if (!text_valid || text_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    text_valid <= 1'b0;
                end
                else if (text_feed.size() == 0 ||
                         (text_feed[0].hold && predicted_tokens.size() != 0))
                    text_valid <= 1'b0;
                else
                begin
                    next_feed  = text_feed.pop_front();
                    text_item  <= next_feed.item;
                    text_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 32);
                        // a third of bursts run straight into the next one
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result, then picks tok_ready from a pattern that
    // bits 9:8 of its counter rx_phase select (always ready, coin flip, one in four,
    // mostly ready).
    // ------------------------------------------------------------------------
    task automatic check_field(input string field_name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %0h actual %0h", $time, field_name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        jat_pkg::tok_item_t want;
        if (!rst_n)
            tok_ready <= 1'b0;
        else
        begin
            if (tok_valid && tok_ready)
            begin
                if (predicted_tokens.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result expected none actual %0h", $time, tok_item);
                end
                else
                begin
                    want = predicted_tokens.pop_front();
                    check_field("byte_valid", 8'(want.byte_valid),
                                8'(tok_item.byte_valid));
                    check_field("token_byte", want.token_byte, tok_item.token_byte);
                    check_field("token_end", 8'(want.token_end),
                                8'(tok_item.token_end));
                    check_field("array_done", 8'(want.array_done),
                                8'(tok_item.array_done));
                    check_field("error_code", 8'(want.error_code),
                                8'(tok_item.error_code));
                    token_ends  += int'(want.token_end);
                    arrays_done += int'(want.array_done);
                    err_seen[want.error_code]++;
                end
            end
            rx_phase++;
            case (rx_phase[9:8])
                2'd0:    tok_ready <= 1'b1;
                2'd1:    tok_ready <= 1'($urandom_range(0, 1));
                2'd2:    tok_ready <= (rx_phase[1:0] == 2'd0);
                default: tok_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves for too long
    // ------------------------------------------------------------------------
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((text_valid && text_ready) || (tok_valid && tok_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// File: json_array_tokenizer_top.f
hdl/jat_pkg.sv
hdl/jat_step.sv
hdl/json_array_tokenizer_top.sv
tb/tb_top.sv
